// ----- src/psc_pkg.sv -----
`default_nettype none

package psc_pkg;

   // field widths of the channels
   localparam int RAW_W       = 24;
   localparam int COEF_W      = 16;
   localparam int TEMP_W      = 15;
   localparam int PRES_W      = 18;
   localparam int CSR_INDEX_W = 3;

   typedef logic        [RAW_W-1:0]       raw_word_type;
   typedef logic        [COEF_W-1:0]      coef_type;
   typedef logic signed [TEMP_W-1:0]      temp_out_type;
   typedef logic        [PRES_W-1:0]      pres_out_type;
   typedef logic        [CSR_INDEX_W-1:0] csr_index_type;

   // calibration register map
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_COEF_C1 = 3'd0,
      CSR_COEF_C2 = 3'd1,
      CSR_COEF_C3 = 3'd2,
      CSR_COEF_C4 = 3'd3,
      CSR_COEF_C5 = 3'd4,
      CSR_COEF_C6 = 3'd5
   } csr_reg_type;

   // temperature arithmetic is carried on 19 bit signed values
   localparam logic signed [18:0] TEMP_REF       = 19'sd2000;
   localparam logic signed [18:0] TEMP_COLD_OFS  = 19'sd3500;
   localparam logic signed [18:0] TEMP_SAT_LO    = -19'sd16384;
   localparam logic signed [18:0] TEMP_SAT_HI    = 19'sd16383;
   localparam temp_out_type       TEMP_OUT_LO    = -15'sd16384;
   localparam temp_out_type       TEMP_OUT_HI    = 15'sd16383;
   localparam pres_out_type       PRES_OUT_MAX   = 18'h3FFFF;

endpackage

`default_nettype wire

// ----- src/psc_if.sv -----
`default_nettype none

// calibration register writes
interface psc_csr_if;
   import psc_pkg::*;
   logic          valid;
   logic          ready;
   csr_index_type index;
   coef_type      data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// raw conversion words in
interface psc_req_if;
   import psc_pkg::*;
   logic         valid;
   logic         ready;
   raw_word_type raw_temperature;
   raw_word_type raw_pressure;
   modport source (output valid, raw_temperature, raw_pressure, input ready);
   modport sink   (input valid, raw_temperature, raw_pressure, output ready);
endinterface

// compensated results out
interface psc_rsp_if;
   import psc_pkg::*;
   logic         valid;
   logic         ready;
   temp_out_type temp_centideg;
   pres_out_type pressure_centimbar;
   modport source (output valid, temp_centideg, pressure_centimbar, input ready);
   modport sink   (input valid, temp_centideg, pressure_centimbar, output ready);
endinterface

`default_nettype wire

// ----- src/pressure_sensor_compensation_top.sv -----
`default_nettype none

// channel    dir   handshake      payload
// csr_chan   in    valid/ready    index (3b), data (16b)    calibration coefficient writes
// req_chan   in    valid/ready    raw_temperature, raw_pressure (24b unsigned each)
// rsp_chan   out   valid/ready    temp_centideg (15b signed), pressure_centimbar (18b)
//
// ten register stages, the last one is the output register; one transfer per cycle
// is taken sustained while the result side is ready
// stall: each stage loads when it is empty or the stage after it moves, so
// bubbles collapse and requests are taken while a result waits
// csr writes are always ready and take effect from the next cycle
// reset (synchronous) clears the coefficients to zero and all stage valids

module pressure_sensor_compensation_top (
   input  logic      clock,
   input  logic      reset,
   psc_csr_if.sink   csr_chan,
   psc_req_if.sink   req_chan,
   psc_rsp_if.source rsp_chan
);
   import psc_pkg::*;

   localparam int NUM_STAGES = 10;

   // ---------------------------------------------------------------
   // calibration coefficients
   // ---------------------------------------------------------------
   coef_type coef_c1_ff, coef_c2_ff, coef_c3_ff, coef_c4_ff, coef_c5_ff, coef_c6_ff;
   coef_type coef_c1_in, coef_c2_in, coef_c3_in, coef_c4_in, coef_c5_in, coef_c6_in;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      coef_c1_in = coef_c1_ff;
      coef_c2_in = coef_c2_ff;
      coef_c3_in = coef_c3_ff;
      coef_c4_in = coef_c4_ff;
      coef_c5_in = coef_c5_ff;
      coef_c6_in = coef_c6_ff;
      if (csr_chan.valid) begin
         case (csr_reg_type'(csr_chan.index))
            CSR_COEF_C1: coef_c1_in = csr_chan.data;
            CSR_COEF_C2: coef_c2_in = csr_chan.data;
            CSR_COEF_C3: coef_c3_in = csr_chan.data;
            CSR_COEF_C4: coef_c4_in = csr_chan.data;
            CSR_COEF_C5: coef_c5_in = csr_chan.data;
            CSR_COEF_C6: coef_c6_in = csr_chan.data;
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   // ---------------------------------------------------------------
   // pipeline flow control
   // ---------------------------------------------------------------
   logic [NUM_STAGES:1]   vld_ff, vld_in;
   logic [NUM_STAGES+1:1] adv;   // adv[k]: stage k register loads this cycle

   always_comb begin
      adv[NUM_STAGES+1] = rsp_chan.ready;
      for (int k = NUM_STAGES; k >= 1; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
      vld_in[1] = adv[1] ? req_chan.valid : vld_ff[1];
      for (int k = 2; k <= NUM_STAGES; k++) begin
         vld_in[k] = adv[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   assign req_chan.ready = adv[1];
   assign rsp_chan.valid = vld_ff[NUM_STAGES];

   // ---------------------------------------------------------------
   // stage 1: dT = D2 - C5 * 2^8
   // ---------------------------------------------------------------
   logic signed [24:0] s1_dt_in, s1_dt_ff;
   raw_word_type       s1_d1_ff;

   assign s1_dt_in = $signed({1'b0, req_chan.raw_temperature})
                   - $signed({1'b0, coef_c5_ff, 8'h00});

   // ---------------------------------------------------------------
   // stage 2: the four products of dT
   // ---------------------------------------------------------------
   logic signed [41:0] s2_mt_in, s2_moff_in, s2_msens_in;
   logic signed [41:0] s2_mt_ff, s2_moff_ff, s2_msens_ff;
   logic signed [49:0] dd_full;
   logic        [47:0] s2_mdd_in, s2_mdd_ff;   // dT^2 is never negative
   raw_word_type       s2_d1_ff;

   always_comb begin
      s2_mt_in    = s1_dt_ff * $signed({1'b0, coef_c6_ff});
      s2_moff_in  = s1_dt_ff * $signed({1'b0, coef_c4_ff});
      s2_msens_in = s1_dt_ff * $signed({1'b0, coef_c3_ff});
      dd_full     = s1_dt_ff * s1_dt_ff;
      s2_mdd_in   = dd_full[47:0];
   end

   // ---------------------------------------------------------------
   // stage 3: truncating shifts, first-order TEMP/OFF/SENS, T2
   // toward-zero division: bias negative values by 2^n - 1 before the shift
   // ---------------------------------------------------------------
   logic signed [41:0] t_bias, o_bias, s_bias;
   logic signed [18:0] tdiv;        // first-order TEMP - 2000
   logic signed [34:0] odiv;
   logic signed [33:0] sdiv;
   logic signed [17:0] s3_dtc_in, s3_dtc_ff;
   logic signed [18:0] s3_tlow_in, s3_tlow_ff;   // first-order TEMP + 1500
   logic signed [39:0] s3_off1_in, s3_off1_ff;
   logic signed [39:0] s3_sens1_in, s3_sens1_ff;
   logic        [16:0] s3_t2_in, s3_t2_ff;
   logic               s3_lt2000_in, s3_lt2000_ff;
   raw_word_type       s3_d1_ff;

   always_comb begin
      t_bias = s2_mt_ff + (s2_mt_ff[41] ? 42'sd8388607 : 42'sd0);
      o_bias = s2_moff_ff + (s2_moff_ff[41] ? 42'sd127 : 42'sd0);
      s_bias = s2_msens_ff + (s2_msens_ff[41] ? 42'sd255 : 42'sd0);
      tdiv   = t_bias[41:23];
      odiv   = o_bias[41:7];
      sdiv   = s_bias[41:8];

      s3_dtc_in    = tdiv[17:0];
      s3_tlow_in   = tdiv + TEMP_COLD_OFS;
      s3_off1_in   = $signed({8'h00, coef_c2_ff, 16'h0000}) + 40'(odiv);
      s3_sens1_in  = $signed({9'h000, coef_c1_ff, 15'h0000}) + 40'(sdiv);
      s3_t2_in     = s2_mdd_ff[47:31];
      s3_lt2000_in = tdiv[18];
   end

   // ---------------------------------------------------------------
   // stage 4: squares for the second-order terms, corrected TEMP
   // ---------------------------------------------------------------
   logic signed [35:0] sq_a;
   logic signed [37:0] sq_b;
   logic        [33:0] s4_a_in, s4_a_ff;
   logic        [33:0] s4_b_in, s4_b_ff;   // only used below -15.00 C
   logic signed [18:0] s4_temp_in, s4_temp_ff;
   logic               s4_lt1500_in, s4_lt1500_ff;
   logic               s4_lt2000_ff;
   logic signed [39:0] s4_off1_ff, s4_sens1_ff;
   raw_word_type       s4_d1_ff;

   always_comb begin
      sq_a         = s3_dtc_ff * s3_dtc_ff;
      sq_b         = s3_tlow_ff * s3_tlow_ff;
      s4_a_in      = sq_a[33:0];
      s4_b_in      = sq_b[33:0];
      s4_lt1500_in = s3_tlow_ff[18];
      s4_temp_in   = TEMP_REF + 19'(s3_dtc_ff)
                   - (s3_lt2000_ff ? $signed({2'b00, s3_t2_ff}) : 19'sd0);
   end

   // ---------------------------------------------------------------
   // stage 5: OFF2 / SENS2 by shift and add, temperature saturation
   // ---------------------------------------------------------------
   logic [36:0] a5, b7;
   logic [35:0] b4;
   logic [37:0] off2;
   logic [36:0] sens2;
   logic [37:0] s5_off2_in, s5_off2_ff;
   logic [36:0] s5_sens2_in, s5_sens2_ff;
   temp_out_type       s5_temp_in, s5_temp_ff;
   logic signed [39:0] s5_off1_ff, s5_sens1_ff;
   raw_word_type       s5_d1_ff;

   always_comb begin
      a5    = 37'(s4_a_ff) + {1'b0, s4_a_ff, 2'b00};
      b7    = {s4_b_ff, 3'b000} - 37'(s4_b_ff);
      b4    = {s4_b_ff, 2'b00};
      off2  = 38'(a5[36:1]) + (s4_lt1500_ff ? 38'(b7) : 38'd0);
      sens2 = 37'(a5[36:3]) + (s4_lt1500_ff ? 37'(b4) : 37'd0);
      s5_off2_in  = s4_lt2000_ff ? off2 : 38'd0;
      s5_sens2_in = s4_lt2000_ff ? sens2 : 37'd0;

      if (s4_temp_ff < TEMP_SAT_LO) begin
         s5_temp_in = TEMP_OUT_LO;
      end else if (s4_temp_ff > TEMP_SAT_HI) begin
         s5_temp_in = TEMP_OUT_HI;
      end else begin
         s5_temp_in = s4_temp_ff[14:0];
      end
   end

   // ---------------------------------------------------------------
   // stage 6: final OFF and SENS
   // ---------------------------------------------------------------
   logic signed [39:0] s6_off_in, s6_off_ff;
   logic signed [39:0] s6_sens_in, s6_sens_ff;
   temp_out_type       s6_temp_ff;
   raw_word_type       s6_d1_ff;

   assign s6_off_in  = s5_off1_ff - $signed({2'b00, s5_off2_ff});
   assign s6_sens_in = s5_sens1_ff - $signed({3'b000, s5_sens2_ff});

   // ---------------------------------------------------------------
   // stage 7: D1 * SENS split in two partial products
   // ---------------------------------------------------------------
   logic        [43:0] s7_pl_in, s7_pl_ff;   // D1 * SENS[19:0]
   logic signed [44:0] s7_ph_in, s7_ph_ff;   // D1 * SENS[39:20]
   logic signed [39:0] s7_off_ff;
   temp_out_type       s7_temp_ff;

   assign s7_pl_in = s6_d1_ff * s6_sens_ff[19:0];
   assign s7_ph_in = $signed({1'b0, s6_d1_ff}) * $signed(s6_sens_ff[39:20]);

   // ---------------------------------------------------------------
   // stage 8: merge the partial products
   // ---------------------------------------------------------------
   logic signed [63:0] s8_p_in, s8_p_ff;
   logic signed [39:0] s8_off_ff;
   temp_out_type       s8_temp_ff;

   assign s8_p_in = (64'(s7_ph_ff) <<< 20) + $signed({20'h00000, s7_pl_ff});

   // ---------------------------------------------------------------
   // stage 9: truncating divide by 2^21
   // ---------------------------------------------------------------
   logic signed [63:0] q_bias;
   logic signed [42:0] s9_q_in, s9_q_ff;
   logic signed [39:0] s9_off_ff;
   temp_out_type       s9_temp_ff;

   assign q_bias  = s8_p_ff + (s8_p_ff[63] ? 64'sd2097151 : 64'sd0);
   assign s9_q_in = q_bias[63:21];

   // ---------------------------------------------------------------
   // stage 10 (output register): subtract OFF, divide by 2^15, saturate
   // a negative difference truncates to zero or below, so it clamps to zero
   // ---------------------------------------------------------------
   logic signed [43:0] r_diff;
   pres_out_type       out_pres_in, out_pres_ff;
   temp_out_type       out_temp_ff;

   always_comb begin
      r_diff = 44'(s9_q_ff) - 44'(s9_off_ff);
      if (r_diff[43]) begin
         out_pres_in = '0;
      end else if (|r_diff[42:33]) begin
         out_pres_in = PRES_OUT_MAX;
      end else begin
         out_pres_in = r_diff[32:15];
      end
   end

   assign rsp_chan.temp_centideg      = out_temp_ff;
   assign rsp_chan.pressure_centimbar = out_pres_ff;

   // ---------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_c1_ff <= '0;
         coef_c2_ff <= '0;
         coef_c3_ff <= '0;
         coef_c4_ff <= '0;
         coef_c5_ff <= '0;
         coef_c6_ff <= '0;
         vld_ff     <= '0;
      end else begin
         coef_c1_ff <= coef_c1_in;
         coef_c2_ff <= coef_c2_in;
         coef_c3_ff <= coef_c3_in;
         coef_c4_ff <= coef_c4_in;
         coef_c5_ff <= coef_c5_in;
         coef_c6_ff <= coef_c6_in;
         vld_ff     <= vld_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (adv[1]) begin
         s1_dt_ff <= s1_dt_in;
         s1_d1_ff <= req_chan.raw_pressure;
      end
      if (adv[2]) begin
         s2_mt_ff    <= s2_mt_in;
         s2_moff_ff  <= s2_moff_in;
         s2_msens_ff <= s2_msens_in;
         s2_mdd_ff   <= s2_mdd_in;
         s2_d1_ff    <= s1_d1_ff;
      end
      if (adv[3]) begin
         s3_dtc_ff    <= s3_dtc_in;
         s3_tlow_ff   <= s3_tlow_in;
         s3_off1_ff   <= s3_off1_in;
         s3_sens1_ff  <= s3_sens1_in;
         s3_t2_ff     <= s3_t2_in;
         s3_lt2000_ff <= s3_lt2000_in;
         s3_d1_ff     <= s2_d1_ff;
      end
      if (adv[4]) begin
         s4_a_ff      <= s4_a_in;
         s4_b_ff      <= s4_b_in;
         s4_temp_ff   <= s4_temp_in;
         s4_lt1500_ff <= s4_lt1500_in;
         s4_lt2000_ff <= s3_lt2000_ff;
         s4_off1_ff   <= s3_off1_ff;
         s4_sens1_ff  <= s3_sens1_ff;
         s4_d1_ff     <= s3_d1_ff;
      end
      if (adv[5]) begin
         s5_off2_ff  <= s5_off2_in;
         s5_sens2_ff <= s5_sens2_in;
         s5_temp_ff  <= s5_temp_in;
         s5_off1_ff  <= s4_off1_ff;
         s5_sens1_ff <= s4_sens1_ff;
         s5_d1_ff    <= s4_d1_ff;
      end
      if (adv[6]) begin
         s6_off_ff  <= s6_off_in;
         s6_sens_ff <= s6_sens_in;
         s6_temp_ff <= s5_temp_ff;
         s6_d1_ff   <= s5_d1_ff;
      end
      if (adv[7]) begin
         s7_pl_ff   <= s7_pl_in;
         s7_ph_ff   <= s7_ph_in;
         s7_off_ff  <= s6_off_ff;
         s7_temp_ff <= s6_temp_ff;
      end
      if (adv[8]) begin
         s8_p_ff    <= s8_p_in;
         s8_off_ff  <= s7_off_ff;
         s8_temp_ff <= s7_temp_ff;
      end
      if (adv[9]) begin
         s9_q_ff    <= s9_q_in;
         s9_off_ff  <= s8_off_ff;
         s9_temp_ff <= s8_temp_ff;
      end
      if (adv[10]) begin
         out_pres_ff <= out_pres_in;
         out_temp_ff <= s9_temp_ff;
      end
   end

`ifndef SYNTHESIS
   // a request transfer always lands in the first stage
   a_req_enters: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> vld_ff[1])
      else $error("request transfer did not reach stage 1");

   // the cold-range flag can only be set inside the low-temperature range
   a_cold_flags: assert property (@(posedge clock) disable iff (reset)
      vld_ff[4] |-> (!s4_lt1500_ff || s4_lt2000_ff))
      else $error("below -15.00 C flagged without below 20.00 C");

   // no second-order offset or sensitivity terms at or above 20.00 C
   a_no_corr_warm: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[4] && adv[5] && !s4_lt2000_ff) |=> (s5_off2_ff == '0 && s5_sens2_ff == '0))
      else $error("second-order terms applied at or above 20.00 C");

   // a full pipe with a stalled output takes no request
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (&vld_ff && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("request accepted into a full stalled pipeline");

   // a negative pressure difference leaves as zero
   a_pres_floor: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[9] && adv[10] && r_diff[43]) |=> (rsp_chan.pressure_centimbar == '0))
      else $error("negative pressure not clamped to zero");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/psc_compensation_checker.sv -----
`timescale 1ns / 100ps

module psc_compensation_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  psc_pkg::csr_index_type csr_index,
   input  psc_pkg::coef_type      csr_data,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  psc_pkg::raw_word_type  req_raw_temperature,
   input  psc_pkg::raw_word_type  req_raw_pressure,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  psc_pkg::temp_out_type  rsp_temp_centideg,
   input  psc_pkg::pres_out_type  rsp_pressure_centimbar,
   output int                     error_count,
   output int                     pending_count,
   output int                     checked_count,
   output int                     cold_count,
   output int                     frigid_count
);
   import psc_pkg::*;

   localparam longint REF_CENTIDEG    = 2000;
   localparam longint FRIGID_CENTIDEG = -1500;
   localparam longint REF_RAW_SCALE   = 256;
   localparam longint TEMP_SCALE      = 64'sd8388608;
   localparam longint OFF_SCALE       = 65536;
   localparam longint OFF_TC_SCALE    = 128;
   localparam longint SENS_SCALE      = 32768;
   localparam longint SENS_TC_SCALE   = 256;
   localparam longint T2_SCALE        = 64'sd2147483648;
   localparam longint PRES_SCALE      = 2097152;
   localparam longint PRES_OUT_SCALE  = 32768;

   typedef struct {
      temp_out_type temp_centideg;
      pres_out_type pressure_centimbar;
   } reading_type;

   coef_type    pres_sens_coef;
   coef_type    pres_off_coef;
   coef_type    sens_tc_coef;
   coef_type    off_tc_coef;
   coef_type    ref_temp_coef;
   coef_type    temp_tc_coef;
   reading_type expected_readings [$];
   int          errors;
   int          checked;
   int          colds;
   int          frigids;

   // compensated reading for one raw pair under the current calibration
   function automatic reading_type compensate(input raw_word_type raw_t,
                                              input raw_word_type raw_p,
                                              output bit cold, output bit frigid);
      longint c1, c2, c3, c4, c5, c6;
      longint d_temp, d_pres, delta, temp, offset, sens, pres;
      longint sq, cold_sq, offset2, sens2;
      reading_type r;
      c1 = pres_sens_coef;
      c2 = pres_off_coef;
      c3 = sens_tc_coef;
      c4 = off_tc_coef;
      c5 = ref_temp_coef;
      c6 = temp_tc_coef;
      d_temp = raw_t;
      d_pres = raw_p;
      delta  = d_temp - c5 * REF_RAW_SCALE;
      temp   = REF_CENTIDEG + (delta * c6) / TEMP_SCALE;
      offset = c2 * OFF_SCALE + (c4 * delta) / OFF_TC_SCALE;
      sens   = c1 * SENS_SCALE + (c3 * delta) / SENS_TC_SCALE;
      cold   = (temp < REF_CENTIDEG);
      frigid = (temp < FRIGID_CENTIDEG);
      // second order below the reference, terms use the first-order temperature
      if (cold) begin
         sq      = (temp - REF_CENTIDEG) * (temp - REF_CENTIDEG);
         offset2 = (5 * sq) / 2;
         sens2   = (5 * sq) / 8;
         if (frigid) begin
            cold_sq = (temp - FRIGID_CENTIDEG) * (temp - FRIGID_CENTIDEG);
            offset2 += 7 * cold_sq;
            sens2   += 4 * cold_sq;
         end
         temp   -= (delta * delta) / T2_SCALE;
         offset -= offset2;
         sens   -= sens2;
      end
      pres = ((d_pres * sens) / PRES_SCALE - offset) / PRES_OUT_SCALE;
      if (temp < longint'(TEMP_OUT_LO)) begin
         temp = TEMP_OUT_LO;
      end else if (temp > longint'(TEMP_OUT_HI)) begin
         temp = TEMP_OUT_HI;
      end
      if (pres < 0) begin
         pres = 0;
      end else if (pres > longint'(PRES_OUT_MAX)) begin
         pres = longint'(PRES_OUT_MAX);
      end
      r.temp_centideg      = temp[TEMP_W-1:0];
      r.pressure_centimbar = pres[PRES_W-1:0];
      compensate = r;
   endfunction

   always @(posedge clock) begin
      reading_type want;
      bit          cold;
      bit          frigid;
      if (reset) begin
         pres_sens_coef = '0;
         pres_off_coef  = '0;
         sens_tc_coef   = '0;
         off_tc_coef    = '0;
         ref_temp_coef  = '0;
         temp_tc_coef   = '0;
         expected_readings.delete();
         errors  = 0;
         checked = 0;
         colds   = 0;
         frigids = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_COEF_C1: pres_sens_coef = csr_data;
               CSR_COEF_C2: pres_off_coef  = csr_data;
               CSR_COEF_C3: sens_tc_coef   = csr_data;
               CSR_COEF_C4: off_tc_coef    = csr_data;
               CSR_COEF_C5: ref_temp_coef  = csr_data;
               CSR_COEF_C6: temp_tc_coef   = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_readings.size() == 0) begin
               errors++;
               $display("%0t: result with none expected, actual temp %0d pressure %0d",
                        $time, rsp_temp_centideg, rsp_pressure_centimbar);
            end else begin
               want = expected_readings.pop_front();
               checked++;
               if (rsp_temp_centideg !== want.temp_centideg) begin
                  errors++;
                  $display("%0t: temp_centideg expected %0d actual %0d",
                           $time, want.temp_centideg, rsp_temp_centideg);
               end
               if (rsp_pressure_centimbar !== want.pressure_centimbar) begin
                  errors++;
                  $display("%0t: pressure_centimbar expected %0d actual %0d",
                           $time, want.pressure_centimbar, rsp_pressure_centimbar);
               end
            end
         end
         if (req_valid && req_ready) begin
            want = compensate(req_raw_temperature, req_raw_pressure, cold, frigid);
            expected_readings.push_back(want);
            if (cold) colds++;
            if (frigid) frigids++;
         end
      end
      error_count   <= errors;
      pending_count <= expected_readings.size();
      checked_count <= checked;
      cold_count    <= colds;
      frigid_count  <= frigids;
   end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
   import psc_pkg::*;

   localparam int     RESET_CYCLES    = 9;
   localparam int     PIPE_LATENCY    = 10;
   // quiet time after the last expected result before a csr write or the verdict
   localparam int     SETTLE_CYCLES   = 2 * PIPE_LATENCY;
   localparam int     HOLD_OFF_CYCLES = 300;
   localparam int     WATCHDOG_LIMIT  = 5000;
   localparam int     RANDOM_PHASES   = 6;
   localparam int     ITEMS_PER_PHASE = 160;
   localparam int     HOLD_OFF_PHASE  = 2;
   localparam longint RAW_MAX         = (64'd1 << RAW_W) - 1;
   localparam longint RAW_PER_REF     = 256;
   localparam longint TEMP_SCALE      = 64'sd8388608;
   // drop from the 20.00 C reference that first takes each cold branch
   localparam longint COLD_STEP       = 1;
   localparam longint FRIGID_STEP     = 3501;
   localparam raw_word_type  RAW_ALL_ONES = '1;
   localparam raw_word_type  RAW_MID      = 24'd8388608;
   localparam csr_index_type CSR_SPARE_LO = 3'd6;
   localparam csr_index_type CSR_SPARE_HI = 3'd7;

   typedef struct {
      coef_type c1;
      coef_type c2;
      coef_type c3;
      coef_type c4;
      coef_type c5;
      coef_type c6;
   } calibration_type;

   // a plausible factory calibration, the starting point for jittered sets
   localparam calibration_type TYPICAL_CAL = '{c1: 16'd40127, c2: 16'd36924,
                                               c3: 16'd23317, c4: 16'd23282,
                                               c5: 16'd33464, c6: 16'd28312};

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   calibration_type cal;
   bit              req_idling = 1'b1;
   bit              rsp_idling = 1'b1;
   bit              hold_off_req = 1'b0;
   int              stuck_cycles = 0;
   int              sent_items = 0;
   int              cal_sets = 0;
   int              held_cycles = 0;
   int              errors;
   int              pending;
   int              checked;
   int              cold_hits;
   int              frigid_hits;

   psc_csr_if csr_chan ();
   psc_req_if req_chan ();
   psc_rsp_if rsp_chan ();

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   pressure_sensor_compensation_top i_dut (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   psc_compensation_checker i_checker (
      .clock                  (clock),
      .reset                  (reset),
      .csr_valid              (csr_chan.valid),
      .csr_ready              (csr_chan.ready),
      .csr_index              (csr_chan.index),
      .csr_data               (csr_chan.data),
      .req_valid              (req_chan.valid),
      .req_ready              (req_chan.ready),
      .req_raw_temperature    (req_chan.raw_temperature),
      .req_raw_pressure       (req_chan.raw_pressure),
      .rsp_valid              (rsp_chan.valid),
      .rsp_ready              (rsp_chan.ready),
      .rsp_temp_centideg      (rsp_chan.temp_centideg),
      .rsp_pressure_centimbar (rsp_chan.pressure_centimbar),
      .error_count            (errors),
      .pending_count          (pending),
      .checked_count          (checked),
      .cold_count             (cold_hits),
      .frigid_count           (frigid_hits)
   );

   // gap length: mostly none or short, now and then a long one
   function automatic int idle_length();
      int roll;
      roll = $urandom_range(99);
      if (roll < 55) begin
         idle_length = 0;
      end else if (roll < 85) begin
         idle_length = $urandom_range(3, 1);
      end else if (roll < 97) begin
         idle_length = $urandom_range(12, 4);
      end else begin
         idle_length = $urandom_range(80, 20);
      end
   endfunction

   function automatic longint raw_clip(input longint v);
      if (v < 0) begin
         raw_clip = 0;
      end else if (v > RAW_MAX) begin
         raw_clip = RAW_MAX;
      end else begin
         raw_clip = v;
      end
   endfunction

   // lowest raw temperature whose first-order value stays above 2000 - drop,
   // minus one: the first raw word that lands in the colder branch
   function automatic longint cold_edge(input longint drop);
      longint tc;
      tc = cal.c6;
      if (tc == 0) begin
         cold_edge = -1;
      end else begin
         cold_edge = longint'(cal.c5) * RAW_PER_REF - (drop * TEMP_SCALE + tc - 1) / tc;
      end
   endfunction

   function automatic raw_word_type raw_between(input longint lo, input longint hi);
      longint a;
      longint b;
      a = raw_clip(lo);
      b = raw_clip(hi);
      if (b < a) b = a;
      raw_between = raw_word_type'(a + longint'($urandom_range(int'(b - a))));
   endfunction

   function automatic coef_type jitter(input coef_type base);
      jitter = base + coef_type'($urandom_range(16000)) - 16'd8000;
   endfunction

   function automatic calibration_type random_calibration(input bit realistic);
      calibration_type c;
      if (realistic) begin
         c.c1 = jitter(TYPICAL_CAL.c1);
         c.c2 = jitter(TYPICAL_CAL.c2);
         c.c3 = jitter(TYPICAL_CAL.c3);
         c.c4 = jitter(TYPICAL_CAL.c4);
         c.c5 = jitter(TYPICAL_CAL.c5);
         c.c6 = jitter(TYPICAL_CAL.c6);
      end else begin
         c.c1 = coef_type'($urandom);
         c.c2 = coef_type'($urandom);
         c.c3 = coef_type'($urandom);
         c.c4 = coef_type'($urandom);
         c.c5 = coef_type'($urandom);
         c.c6 = coef_type'($urandom);
      end
      random_calibration = c;
   endfunction

   // one csr transfer, valid stays up for a following write
   task automatic write_csr(input csr_index_type index, input coef_type value);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= index;
      csr_chan.data  <= value;
      do @(posedge clock); while (!csr_chan.ready);
   endtask

   // one request transfer, preceded by an optional gap
   task automatic send_reading(input raw_word_type raw_t, input raw_word_type raw_p);
      int gap;
      gap = req_idling ? idle_length() : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid           <= 1'b1;
      req_chan.raw_temperature <= raw_t;
      req_chan.raw_pressure    <= raw_p;
      do @(posedge clock); while (!req_chan.ready);
      sent_items++;
   endtask

   // stop offering and wait until every expected result has come back
   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // new calibration, only ever loaded with the pipeline empty
   task automatic load_calibration(input calibration_type set, input bit poke_spare);
      drain();
      cal = set;
      write_csr(CSR_COEF_C1, set.c1);
      write_csr(CSR_COEF_C2, set.c2);
      write_csr(CSR_COEF_C3, set.c3);
      write_csr(CSR_COEF_C4, set.c4);
      write_csr(CSR_COEF_C5, set.c5);
      write_csr(CSR_COEF_C6, set.c6);
      // indexes past the last coefficient must leave the calibration alone
      if (poke_spare) begin
         write_csr(CSR_SPARE_LO, coef_type'($urandom));
         write_csr(CSR_SPARE_HI, coef_type'($urandom));
      end
      csr_chan.valid <= 1'b0;
      cal_sets++;
   endtask

   // both sides of the 20.00 C and -15.00 C thresholds
   task automatic send_threshold_pairs();
      send_reading(raw_word_type'(raw_clip(cold_edge(COLD_STEP))), RAW_MID);
      send_reading(raw_word_type'(raw_clip(cold_edge(COLD_STEP) + 1)), RAW_MID);
      send_reading(raw_word_type'(raw_clip(cold_edge(FRIGID_STEP))), RAW_MID);
      send_reading(raw_word_type'(raw_clip(cold_edge(FRIGID_STEP) + 1)), RAW_MID);
   endtask

   // temperatures spread over warm, cold and very cold, pressures over the full word
   task automatic run_random_phase(input int count);
      raw_word_type raw_t;
      raw_word_type raw_p;
      longint       ref_raw;
      int           roll;
      ref_raw = longint'(cal.c5) * RAW_PER_REF;
      repeat (count) begin
         roll = $urandom_range(99);
         if (roll < 30) begin
            raw_t = raw_word_type'($urandom);
         end else if (roll < 60) begin
            raw_t = raw_between(ref_raw - 4000, ref_raw + 4000);
         end else if (roll < 80) begin
            raw_t = raw_between(cold_edge(FRIGID_STEP), cold_edge(COLD_STEP));
         end else begin
            raw_t = raw_between(cold_edge(FRIGID_STEP) - 3000000, cold_edge(FRIGID_STEP));
         end
         roll = $urandom_range(99);
         if (roll < 8) begin
            raw_p = '0;
         end else if (roll < 16) begin
            raw_p = RAW_ALL_ONES;
         end else begin
            raw_p = raw_word_type'($urandom);
         end
         send_reading(raw_t, raw_p);
      end
   endtask

   // result side: random ready, plus one long hold-off when asked for
   initial begin
      int gap_left;
      gap_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            held_cycles += HOLD_OFF_CYCLES;
            rsp_chan.ready <= 1'b1;
         end else if (gap_left > 0) begin
            rsp_chan.ready <= 1'b0;
            gap_left--;
         end else begin
            rsp_chan.ready <= 1'b1;
            if (rsp_idling) gap_left = idle_length();
         end
      end
   end

   // watchdog: any transfer on any channel counts as progress
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
          (csr_chan.valid && csr_chan.ready)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
      if (stuck_cycles == WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      calibration_type hot_cal;
      calibration_type flat_cal;
      csr_chan.valid           <= 1'b0;
      csr_chan.index           <= '0;
      csr_chan.data            <= '0;
      req_chan.valid           <= 1'b0;
      req_chan.raw_temperature <= '0;
      req_chan.raw_pressure    <= '0;
      cal = '{c1: '0, c2: '0, c3: '0, c4: '0, c5: '0, c6: '0};
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // coefficients still at their reset value
      send_reading('0, '0);
      send_reading(RAW_ALL_ONES, RAW_ALL_ONES);

      // typical calibration: worked example, zero delta, thresholds, word extremes
      load_calibration(TYPICAL_CAL, 1'b1);
      send_reading(24'd8569150, 24'd9085466);
      send_reading(raw_word_type'(longint'(cal.c5) * RAW_PER_REF), RAW_MID);
      send_threshold_pairs();
      send_reading('0, RAW_ALL_ONES);
      send_reading(RAW_ALL_ONES, '0);

      // every coefficient at its top: deep cold for low raw words, where temperature saturates low
      load_calibration('{c1: '1, c2: '1, c3: '1, c4: '1, c5: '1, c6: '1}, 1'b0);
      send_reading(RAW_ALL_ONES, RAW_ALL_ONES);
      send_reading('0, RAW_ALL_ONES);
      send_reading('0, '0);
      send_threshold_pairs();

      // zero reference with the steepest slope: temperature saturates high
      hot_cal = TYPICAL_CAL;
      hot_cal.c5 = '0;
      hot_cal.c6 = '1;
      load_calibration(hot_cal, 1'b0);
      send_reading(RAW_ALL_ONES, RAW_ALL_ONES);
      send_reading(RAW_ALL_ONES, '0);

      // every coefficient written as zero
      flat_cal = '{c1: '0, c2: '0, c3: '0, c4: '0, c5: '0, c6: '0};
      load_calibration(flat_cal, 1'b0);
      send_reading(RAW_ALL_ONES, 24'd1);

      // random part: jittered and fully random calibrations in turn
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         load_calibration(random_calibration(ph % 2 == 0), 1'b0);
         // first phase runs back to back on both sides
         req_idling = (ph != 0);
         rsp_idling = (ph != 0);
         // sender keeps offering while the result side holds off, so the pipe fills
         if (ph == HOLD_OFF_PHASE) begin
            req_idling = 1'b0;
            hold_off_req = 1'b1;
         end
         run_random_phase(ITEMS_PER_PHASE);
      end
      drain();

      $display("%0d readings under %0d calibrations, %0d results checked",
               sent_items, cal_sets, checked);
      $display("%0d took the second-order correction, %0d the extra cold term, %0d stall cycles",
               cold_hits, frigid_hits, held_cycles);
      if (errors == 0 && pending == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
